// ===== sv/sau_pkg.sv =====
`default_nettype none
package sau_pkg;

    // Table size: samples over [0,8), plus one end point at 8.0
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam int FRAC_W = 15;
    localparam int POS_W = FRAC_W + IDX_W;
    localparam int TAYLOR_TERMS = 24;

    // Step 8/TABLE_ENTRIES in Q0.32
    localparam logic [63:0] STEP_Q32 = 64'd34359738368 / TABLE_ENTRIES;

    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample_or_gradient;
        logic [15:0]        prior_activation;
        logic               vector_end_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        activation;
        logic signed [15:0] gradient_out;
        logic               vector_end_out;
    } t_out_item;

    typedef logic [TABLE_ENTRIES:0][15:0] t_rom;

    // Shift-subtract divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // rom[i] = 1 / (1 + exp(-8i/N)) in Q0.16, exp by Taylor series and repeated products
    function automatic t_rom build_rom();
        logic [63:0]  term;
        logic [63:0]  pos_sum;
        logic [63:0]  neg_sum;
        logic [63:0]  e1;
        logic [63:0]  e;
        logic [63:0]  den;
        logic [63:0]  quo;
        logic [127:0] prod;
        t_rom         rom;
        term = 64'd4294967296;
        pos_sum = 64'd4294967296;
        neg_sum = '0;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            prod = {64'd0, term} * {64'd0, STEP_Q32};
            term = udiv64(prod[95:32], 64'(k));
            if (k % 2 == 1) begin
                neg_sum = neg_sum + term;
            end else begin
                pos_sum = pos_sum + term;
            end
        end
        e1 = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
        e = 64'd4294967296;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            if (i > 0) begin
                prod = {64'd0, e} * {64'd0, e1} + 128'd2147483648;
                e = prod[95:32];
            end
            den = 64'd4294967296 + e;
            quo = udiv64(64'd281474976710656 + (den >> 1), den);
            rom[i] = quo[15:0];
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

endpackage
`default_nettype wire

// ===== sv/sigmoid_activation_unit_core.sv =====
`default_nettype none
// Elementwise logistic sigmoid unit, fixed point.
// Input channel: i_valid / o_stall with payload i_item (sau_pkg::t_in_item).
//   opcode 0: sample (Q4.12) -> activation sigmoid(x) in Q0.16, gradient_out 0.
//   opcode 1: gradient g (Q4.12) and prior activation o (Q0.16) ->
//             gradient_out = g*o*(1-o) in Q4.12, rounded, saturated; activation 0.
//   vector_end_in is carried through to vector_end_out.
// Output channel: o_valid / i_stall with payload o_item (sau_pkg::t_out_item).
// An item is taken on a clock edge where valid is high and stall is low.
// Pipeline: four register stages (abs/index and o*(1-o), table read and g*p,
//   slope*frac and gradient round, interpolation add and output register).
// Throughput: one item per cycle while i_stall is low; each stage holds a valid
//   bit and moves when the stage after it is empty or moving, so bubbles are
//   squeezed out.
// When the receiver stalls, the output register holds; earlier stages keep
// filling until the pipe is full, then o_stall rises. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; the table is constant
// logic and needs no fill.
module sigmoid_activation_unit_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire sau_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sau_pkg::t_out_item     o_item
);

    localparam int IDX_W = sau_pkg::IDX_W;
    localparam int FRAC_W = sau_pkg::FRAC_W;
    localparam int POS_W = sau_pkg::POS_W;

    // stage valid bits and advance enables
    logic r_va, r_vb, r_vc, r_vd;
    logic en_a, en_b, en_c, en_d;

    assign en_d = !r_vd || !i_stall;
    assign en_c = !r_vc || en_d;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_vd;

    // ---------------- stage A: magnitude, table position, o*(1-o)
    logic [16:0]      n_mag;
    logic [POS_W-1:0] n_pos;
    logic [16:0]      n_omc;
    logic [31:0]      n_p;

    always_comb begin
        if (i_item.sample_or_gradient[15]) begin
            n_mag = 17'd0 - {i_item.sample_or_gradient[15], i_item.sample_or_gradient};
        end else begin
            n_mag = {1'b0, i_item.sample_or_gradient};
        end
        n_pos = POS_W'(n_mag * sau_pkg::TABLE_ENTRIES);
        n_omc = 17'h10000 - {1'b0, i_item.prior_activation};
        n_p = 32'({1'b0, i_item.prior_activation} * n_omc);
    end

    logic              r_a_op, r_a_neg, r_a_ve;
    logic [IDX_W-1:0]  r_a_idx;
    logic [FRAC_W-1:0] r_a_frac;
    logic [16:0]       r_a_mag;
    logic [31:0]       r_a_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en_a) begin
            r_va <= i_valid;
        end
        if (en_a) begin
            r_a_op <= i_item.opcode;
            r_a_neg <= i_item.sample_or_gradient[15];
            r_a_ve <= i_item.vector_end_in;
            r_a_idx <= n_pos[POS_W-1:FRAC_W];
            r_a_frac <= n_pos[FRAC_W-1:0];
            r_a_mag <= n_mag;
            r_a_p <= n_p;
        end
    end

    // ---------------- stage B: table read, |g|*p
    logic [IDX_W-1:0] n_idx_hi;
    logic [15:0]      n_lo, n_hi;
    logic [47:0]      n_gp;

    always_comb begin
        if (r_a_idx < IDX_W'(sau_pkg::TABLE_ENTRIES)) begin
            n_idx_hi = r_a_idx + IDX_W'(1);
        end else begin
            n_idx_hi = r_a_idx;
        end
        n_lo = sau_pkg::ROM[r_a_idx];
        n_hi = sau_pkg::ROM[n_idx_hi];
        n_gp = 48'(r_a_mag * r_a_p);
    end

    logic              r_b_op, r_b_neg, r_b_ve;
    logic [FRAC_W-1:0] r_b_frac;
    logic [15:0]       r_b_lo, r_b_hi;
    logic [47:0]       r_b_gp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en_b) begin
            r_vb <= r_va;
        end
        if (en_b) begin
            r_b_op <= r_a_op;
            r_b_neg <= r_a_neg;
            r_b_ve <= r_a_ve;
            r_b_frac <= r_a_frac;
            r_b_lo <= n_lo;
            r_b_hi <= n_hi;
            r_b_gp <= n_gp;
        end
    end

    // ---------------- stage C: slope times fraction, gradient round and clamp
    logic        n_dneg;
    logic [15:0] n_dabs;
    logic [30:0] n_prod;
    logic [47:0] n_gr_sum;
    logic [15:0] n_r;
    logic [15:0] n_grad;

    always_comb begin
        n_dneg = r_b_hi < r_b_lo;
        n_dabs = n_dneg ? (r_b_lo - r_b_hi) : (r_b_hi - r_b_lo);
        n_prod = 31'(n_dabs * r_b_frac);
        n_gr_sum = r_b_gp + 48'h0000_8000_0000;
        n_r = n_gr_sum[47:32];
        if (r_b_neg) begin
            // -r saturates at -32768
            n_grad = (n_r > 16'h8000) ? 16'h8000 : (16'd0 - n_r);
        end else begin
            n_grad = (n_r > 16'h7FFF) ? 16'h7FFF : n_r;
        end
    end

    logic        r_c_op, r_c_neg, r_c_ve, r_c_dneg;
    logic [15:0] r_c_lo;
    logic [30:0] r_c_prod;
    logic [15:0] r_c_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en_c) begin
            r_vc <= r_vb;
        end
        if (en_c) begin
            r_c_op <= r_b_op;
            r_c_neg <= r_b_neg;
            r_c_ve <= r_b_ve;
            r_c_dneg <= n_dneg;
            r_c_lo <= r_b_lo;
            r_c_prod <= n_prod;
            r_c_grad <= n_grad;
        end
    end

    // ---------------- stage D: interpolate, mirror for negative x, output register
    logic [30:0]        n_adj_sum;
    logic [15:0]        n_adj;
    logic signed [17:0] n_y;
    logic [16:0]        n_yc;
    logic [16:0]        n_act;
    sau_pkg::t_out_item n_out;

    always_comb begin
        n_adj_sum = r_c_prod + 31'd16384;
        n_adj = n_adj_sum[30:15];
        if (r_c_dneg) begin
            n_y = $signed({2'b00, r_c_lo}) - $signed({2'b00, n_adj});
        end else begin
            n_y = $signed({2'b00, r_c_lo}) + $signed({2'b00, n_adj});
        end
        if (n_y < 0) begin
            n_yc = 17'd0;
        end else if (n_y > 18'sd65536) begin
            n_yc = 17'h10000;
        end else begin
            n_yc = n_y[16:0];
        end
        if (r_c_neg) begin
            n_act = 17'h10000 - n_yc;
        end else begin
            n_act = (n_yc > 17'h0FFFF) ? 17'h0FFFF : n_yc;
        end
        n_out.vector_end_out = r_c_ve;
        if (r_c_op == sau_pkg::OP_BACKWARD) begin
            n_out.activation = '0;
            n_out.gradient_out = $signed(r_c_grad);
        end else begin
            n_out.activation = n_act[15:0];
            n_out.gradient_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en_d) begin
            r_vd <= r_vc;
        end
        if (en_d) begin
            o_item <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    typedef longint unsigned t_u64;

    localparam int IDLE_LIMIT   = 1000;  // cycles with no handshake on either side
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // pipe is 4 deep; extra margin at the end

    logic                clk = 1'b0;
    logic                rst_n;
    logic                i_valid;
    logic                o_stall;
    sau_pkg::t_in_item   i_item;
    logic                o_valid;
    logic                i_stall;
    sau_pkg::t_out_item  o_item;

    // Q0.16 sigmoid samples at 8*i/TABLE_ENTRIES, i = 0 .. TABLE_ENTRIES
    logic [15:0] sig_knots [0:sau_pkg::TABLE_ENTRIES];

    sau_pkg::t_out_item pending_sigmoid_results [$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          gap_max     = 0;
    int          vec_left    = 1;
    bit          rx_throttle = 1'b0;
    int          hold_cycles = 0;

    sigmoid_activation_unit_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Knot values: exp(-8/N) from a truncated Taylor series in Q0.32, powers of it
    // by rounded products, then 1/(1+e) in Q0.16 rounded to nearest.
    initial begin : knot_build
        t_u64 knot_dx, term, pos_sum, neg_sum, e1, e, den;
        knot_dx = 64'd34359738368 / t_u64'(sau_pkg::TABLE_ENTRIES);
        term    = 64'd4294967296;
        pos_sum = 64'd4294967296;
        neg_sum = 64'd0;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * knot_dx) >> 32) / t_u64'(k);
            if (k % 2 == 1) begin
                neg_sum += term;
            end else begin
                pos_sum += term;
            end
        end
        e1 = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
        e  = 64'd4294967296;
        for (int i = 0; i <= sau_pkg::TABLE_ENTRIES; i++) begin
            if (i > 0) begin
                e = (e * e1 + 64'd2147483648) >> 32;
            end
            den = 64'd4294967296 + e;
            sig_knots[i] = 16'((64'd281474976710656 + den / 2) / den);
        end
    end

    // Forward: |x| to knot index and 15-bit fraction, interpolate with the
    // correction rounded half away from zero, mirror for negative x.
    function automatic logic [15:0] sigmoid_q16(input logic signed [15:0] x);
        longint mag, scaled, idx, frac, lo, hi, diff, adj, y;
        mag    = x;
        mag    = (mag < 0) ? -mag : mag;
        scaled = mag * sau_pkg::TABLE_ENTRIES;
        idx    = scaled >> 15;
        frac   = scaled & 64'h7FFF;
        if (idx > sau_pkg::TABLE_ENTRIES) begin
            idx = sau_pkg::TABLE_ENTRIES;
        end
        lo   = sig_knots[idx];
        hi   = (idx < sau_pkg::TABLE_ENTRIES) ? longint'(sig_knots[idx + 1]) : lo;
        diff = hi - lo;
        if (diff >= 0) begin
            adj = (diff * frac + 16384) / 32768;
        end else begin
            adj = -((-diff * frac + 16384) / 32768);
        end
        y = lo + adj;
        if (y < 0) begin
            y = 0;
        end
        if (y > 65536) begin
            y = 65536;
        end
        if (x >= 0) begin
            return (y > 65535) ? 16'hFFFF : y[15:0];
        end
        return 16'(65536 - y);
    endfunction

    // Backward: g * o * (1 - o) with o*(1 - o) in Q0.32, product rounded half away
    // from zero back to Q4.12, then clamped to the signed 16-bit range.
    function automatic logic signed [15:0] sigmoid_grad_q12(input logic signed [15:0] g,
                                                           input logic [15:0] o);
        t_u64   slope, mag, r;
        longint gs, s;
        gs    = g;
        slope = t_u64'(o) * (t_u64'(65536) - t_u64'(o));
        mag   = t_u64'((gs < 0) ? -gs : gs) * slope;
        r     = (mag + 64'd2147483648) >> 32;
        if (gs < 0) begin
            s = -longint'(r);
            if (s < -32768) begin
                s = -32768;
            end
        end else begin
            s = longint'(r);
            if (s > 32767) begin
                s = 32767;
            end
        end
        return s[15:0];
    endfunction

    function automatic sau_pkg::t_out_item sigmoid_unit_predict(input sau_pkg::t_in_item it);
        sau_pkg::t_out_item res;
        res = '0;
        if (it.opcode == sau_pkg::OP_FORWARD) begin
            res.activation = sigmoid_q16(it.sample_or_gradient);
        end else begin
            res.gradient_out = sigmoid_grad_q12(it.sample_or_gradient, it.prior_activation);
        end
        res.vector_end_out = it.vector_end_in;
        return res;
    endfunction

    function automatic sau_pkg::t_in_item make_item(input logic op, input logic [15:0] val,
                                                    input logic [15:0] act,
                                                    input logic last);
        sau_pkg::t_in_item it;
        it.opcode             = op;
        it.sample_or_gradient = val;
        it.prior_activation   = act;
        it.vector_end_in      = last;
        return it;
    endfunction

    // Random element of a vector; vectors are 1..16 items long.
    function automatic sau_pkg::t_in_item random_element();
        sau_pkg::t_in_item  it;
        logic signed [15:0] x;
        logic [15:0]        o;
        int                 m;
        case ($urandom_range(0, 4))
            0: x = 16'($urandom_range(0, 2047) - 1024);        // near zero
            1: begin                                           // near +-8.0
                m = $urandom_range(32000, 32768);
                x = ($urandom_range(0, 1) || m == 32768) ? 16'(-m) : 16'(m);
            end
            2: begin                                           // exactly on a knot
                m = $urandom_range(0, sau_pkg::TABLE_ENTRIES - 1)
                    * (32768 / sau_pkg::TABLE_ENTRIES);
                x = $urandom_range(0, 1) ? 16'(-m) : 16'(m);
            end
            default: x = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: o = 16'h0000;
                    1: o = 16'h0001;
                    2: o = 16'h8000;
                    default: o = 16'hFFFF;
                endcase
            end
            1: o = sigmoid_q16(16'($urandom));                 // realistic prior output
            default: o = 16'($urandom);
        endcase
        vec_left--;
        it = make_item($urandom_range(0, 1) ? sau_pkg::OP_BACKWARD : sau_pkg::OP_FORWARD,
                       x, o, vec_left == 0);
        if (vec_left == 0) begin
            vec_left = $urandom_range(1, 16);
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the handshake.
    // Valid stays high across a burst; a gap drops it for a random count of cycles.
    task automatic send_item(input sau_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do begin
            @(posedge clk);
        end while (o_stall);
        pending_sigmoid_results.push_back(sigmoid_unit_predict(it));
        burst_left--;
        @(negedge clk);
    endtask

    // Zero, smallest steps, +-1.0, both sides of a knot, the last knot below 8.0,
    // positive limit, and the magnitude of eight.
    task automatic test_forward_corners();
        logic [15:0] samples [11];
        samples = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000, 16'h007F,
                    16'h0080, 16'h7F80, 16'h7FFF, 16'h8001, 16'h8000};
        gap_max     = 3;
        rx_throttle = 1'b1;
        foreach (samples[i]) begin
            send_item(make_item(sau_pkg::OP_FORWARD, samples[i], 16'($urandom),
                                i % 2 == 1));
        end
    endtask

    // Peak of o*(1-o) with full-scale gradients, zero gradient, o at both ends,
    // smallest gradients.
    task automatic test_backward_corners();
        logic [15:0] grads [10];
        logic [15:0] priors [10];
        grads  = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF,
                   16'h8000, 16'hFFFF, 16'h0001, 16'h1000, 16'hB1E0};
        priors = '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                   16'h0001, 16'h8000, 16'h8000, 16'hC000, 16'h3039};
        foreach (grads[i]) begin
            send_item(make_item(sau_pkg::OP_BACKWARD, grads[i], priors[i], i % 3 == 0));
        end
    endtask

    task automatic test_random_stream(input int n);
        gap_max     = 8;
        rx_throttle = 1'b1;
        repeat (n) begin
            send_item(random_element());
        end
    endtask

    // Receiver holds off while items keep coming; the pipe fills and o_stall rises.
    task automatic test_backpressure(input int n);
        gap_max     = 0;
        hold_cycles = HOLD_CYCLES;
        repeat (n) begin
            send_item(random_element());
        end
    endtask

    // Full rate both ways: no gaps, no stalls.
    task automatic test_full_rate(input int n);
        gap_max     = 0;
        rx_throttle = 1'b0;
        repeat (n) begin
            send_item(random_element());
        end
    endtask

    // Receiver pattern: free runs of varying length (sometimes long) and short
    // stall runs, or a long hold when one is requested.
    initial begin : receiver_pattern
        int   free_left;
        int   busy_left;
        logic stall_next;
        free_left = 0;
        busy_left = 0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                i_stall <= 1'b0;
            end else if (!rx_throttle) begin
                i_stall <= 1'b0;
            end else begin
                if (free_left == 0 && busy_left == 0) begin
                    free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                            : $urandom_range(0, 5);
                    busy_left = $urandom_range(1, 5);
                end
                if (free_left > 0) begin
                    stall_next = 1'b0;
                    free_left--;
                end else begin
                    stall_next = 1'b1;
                    busy_left--;
                end
                i_stall <= stall_next;
            end
        end
    end

    // Each accepted result against the oldest expectation.
    always @(posedge clk) begin : result_check
        sau_pkg::t_out_item want;
        if (rst_n && o_valid && !i_stall) begin
            if (pending_sigmoid_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result act=%h grad=%h end=%b",
                             $time, o_item.activation, o_item.gradient_out,
                             o_item.vector_end_out);
                end
            end else begin
                want = pending_sigmoid_results.pop_front();
                if (o_item.activation !== want.activation ||
                    o_item.gradient_out !== want.gradient_out ||
                    o_item.vector_end_out !== want.vector_end_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: want act=%h grad=%h end=%b, got act=%h grad=%h end=%b",
                                 $time, want.activation, want.gradient_out,
                                 want.vector_end_out, o_item.activation,
                                 o_item.gradient_out, o_item.vector_end_out);
                    end
                end
            end
        end
    end

    // Ends the run if neither side completes a handshake for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n   = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_forward_corners();
        test_backward_corners();
        test_random_stream(300);
        test_backpressure(60);
        test_full_rate(140);

        i_valid     <= 1'b0;
        rx_throttle = 1'b1;
        while (pending_sigmoid_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sigmoid_activation_unit_core.f =====
sv/sau_pkg.sv
sv/sigmoid_activation_unit_core.sv
verif/tb.sv
